/* hdl/swcb_pkg.sv */
// ----------------------------------------------------------------------------
// swcb_pkg
// Shared types, constants and small tables for the sliding window clock
// bitmap: register codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package swcb_pkg;

  // Storage and field widths
  localparam int unsigned CellDepth  = 65536;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned CellW      = 16;
  localparam int unsigned CntW       = 17;
  localparam int unsigned WinW       = 21;
  localparam int unsigned BitsW      = 5;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned RoundW     = 4;
  localparam int unsigned HashRounds = 9;
  localparam int unsigned DivW       = 32;
  localparam int unsigned DivStepW   = 5;

  localparam logic [DataW-1:0] Golden  = 32'h9e3779b9;
  localparam logic [BitsW-1:0] MinBits = 5'd2;
  localparam logic [BitsW-1:0] MaxBits = 5'd16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CELL_COUNT = 2'd0,
    REG_WINDOW     = 2'd1,
    REG_BITS       = 2'd2,
    REG_SEED       = 2'd3
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // Controller states, one-hot
  typedef enum logic [20:0] {
    S_CLEAR   = 21'h000001,
    S_IDLE    = 21'h000002,
    S_CNT_RD  = 21'h000004,
    S_CNT_CHK = 21'h000008,
    S_HASH    = 21'h000010,
    S_MOD_GO  = 21'h000020,
    S_MOD_W   = 21'h000040,
    S_SET_RD  = 21'h000080,
    S_SET_WR  = 21'h000100,
    S_MUL     = 21'h000200,
    S_TMP_GO  = 21'h000400,
    S_TMP_W   = 21'h000800,
    S_SPL_GO  = 21'h001000,
    S_SPL_W   = 21'h002000,
    S_PTR_GO  = 21'h004000,
    S_PTR_W   = 21'h008000,
    S_ALL_RD  = 21'h010000,
    S_ALL_WR  = 21'h020000,
    S_LFT_RD  = 21'h040000,
    S_LFT_WR  = 21'h080000,
    S_DONE    = 21'h100000
  } state_t;

  // Divider operand selection
  typedef enum logic [1:0] {
    DV_MOD   = 2'd0,
    DV_TEMP  = 2'd1,
    DV_SPLIT = 2'd2,
    DV_PTR   = 2'd3
  } div_sel_t;

  // Sweep address load source
  typedef enum logic [1:0] {
    LD_NONE = 2'd0,
    LD_ZERO = 2'd1,
    LD_DIVR = 2'd2,
    LD_PTR  = 2'd3
  } load_t;

  // Sweep length
  typedef enum logic [1:0] {
    LIM_FULL = 2'd0,
    LIM_N    = 2'd1,
    LIM_LEFT = 2'd2
  } lim_t;

  // Cell write kind
  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CLEAR = 2'd1,
    WR_SET   = 2'd2,
    WR_DEC   = 2'd3
  } wr_t;

  // Which hash word one mix row updates
  typedef enum logic [1:0] {
    ROW_A = 2'd0,
    ROW_B = 2'd1,
    ROW_C = 2'd2
  } row_t;

  typedef struct packed {
    logic     accept;
    logic     clean;
    logic     zc_clear;
    logic     zc_count;
    logic     hash_round;
    logic     div_start;
    logic     div_wait;
    div_sel_t div_sel;
    load_t    load;
    logic     step;
    logic     wrap;
    lim_t     lim;
    wr_t      wr;
    logic     dec_one;
    logic     mul;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic dirty;
    logic op_insert;
    logic round_last;
    logic div_done;
    logic cnt_last;
    logic sub_zero;
    logic left_zero;
    logic out_free;
  } stat_t;

  // Mix row of each hash round
  function automatic row_t row_of(input logic [RoundW-1:0] r);
    row_t res;
    case (r) inside
      4'd0, 4'd3, 4'd6: res = ROW_A;
      4'd1, 4'd4, 4'd7: res = ROW_B;
      default:          res = ROW_C;
    endcase
    return res;
  endfunction

  // Shift amount of each hash round
  function automatic logic [4:0] shift_of(input logic [RoundW-1:0] r);
    logic [4:0] res;
    case (r)
      4'd0:    res = 5'd13;
      4'd1:    res = 5'd8;
      4'd2:    res = 5'd13;
      4'd3:    res = 5'd12;
      4'd4:    res = 5'd16;
      4'd5:    res = 5'd5;
      4'd6:    res = 5'd3;
      4'd7:    res = 5'd10;
      default: res = 5'd15;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/sliding_window_clock_bitmap.sv */
// ----------------------------------------------------------------------------
// sliding_window_clock_bitmap
// Sliding-window distinct-count bitmap built from clock counters.
// ----------------------------------------------------------------------------
// After reset the block clears all 65536 cells, one per cycle, and takes no
// request until that clear pass is done. A query needs no hash or division. An
// insert runs the hash rounds, then four divisions on the one shared
// divider (cell modulo, tick amount, its split into whole and partial decay,
// sweep pointer modulo) and a few control states, then sweeps cells:
// all n cells when the tick decays every cell, and the partial run after that.
// Each swept cell costs a read and a write on the single-port cell memory.
// The first request after reset or after a cell_count write also recounts
// zero cells. One request is in flight at a time; the next one is taken
// while the last result is still waiting at the output.
`default_nettype none

module sliding_window_clock_bitmap
  import swcb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [DataW-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic [DataW-1:0]   key,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [AddrW-1:0]        cell_index,
  output logic [CntW-1:0]         zero_cells
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  swcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  swcb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .key        (key),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .cell_index (cell_index),
    .zero_cells (zero_cells)
  );

  // Block goes busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block did not go busy");

  // A result only appears out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without work in progress");

  // Divider start never coincides with waiting on it
  a_div_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_start && cmd.div_wait))
    else $error("divider started while waiting on it");

endmodule

`default_nettype wire

/* hdl/swcb_div.sv */
// ----------------------------------------------------------------------------
// swcb_div
// Restoring divider, one quotient bit per cycle. Operands must hold while
// busy; quotient and remainder hold after the done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module swcb_div
  import swcb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DivW-1:0]  dividend,
  input  wire logic [WinW-1:0]  divisor,
  output logic                  done,
  output logic [DivW-1:0]       quotient,
  output logic [WinW-1:0]       remainder
);

  logic                busy;
  logic [DivStepW-1:0] count;
  logic [WinW:0]       trial;
  logic [WinW:0]       diff;
  logic                ge;

  // Shift in one dividend bit and try the subtract
  assign trial = {remainder, quotient[DivW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= '0;
        remainder <= '0;
        quotient  <= dividend;
      end else if (busy) begin
        remainder <= ge ? diff[WinW-1:0] : trial[WinW-1:0];
        quotient  <= {quotient[DivW-2:0], ge};
        count     <= count + 1'b1;
        if (count == DivStepW'(DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/swcb_ctrl.sv */
// ----------------------------------------------------------------------------
// swcb_ctrl
// Sequencer: clear pass, zero recount, hash, divisions, cell sweeps and
// result hand-off, issued to the datapath as one command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module swcb_ctrl
  import swcb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  op,
  input  wire stat_t stat,
  output logic       in_stall,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DV_MOD;
    cmd.load    = LD_NONE;
    cmd.lim     = LIM_N;
    cmd.wr      = WR_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.wr   = WR_CLEAR;
        cmd.step = 1'b1;
        cmd.lim  = LIM_FULL;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.dirty) begin
            cmd.load     = LD_ZERO;
            cmd.zc_clear = 1'b1;
            state_next   = S_CNT_RD;
          end else if (op == OP_INSERT) begin
            state_next = S_HASH;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CNT_RD: begin
        state_next = S_CNT_CHK;
      end
      S_CNT_CHK: begin
        cmd.zc_count = 1'b1;
        cmd.step     = 1'b1;
        cmd.wrap     = 1'b1;
        if (stat.cnt_last) begin
          cmd.clean  = 1'b1;
          state_next = stat.op_insert ? S_HASH : S_DONE;
        end else begin
          state_next = S_CNT_RD;
        end
      end
      S_HASH: begin
        cmd.hash_round = 1'b1;
        if (stat.round_last) begin
          state_next = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_MOD_W;
      end
      S_MOD_W: begin
        cmd.div_wait = 1'b1;
        if (stat.div_done) begin
          cmd.load   = LD_DIVR;
          state_next = S_SET_RD;
        end
      end
      S_SET_RD: begin
        state_next = S_SET_WR;
      end
      S_SET_WR: begin
        cmd.wr     = WR_SET;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_TMP_GO;
      end
      S_TMP_GO: begin
        cmd.div_sel   = DV_TEMP;
        cmd.div_start = 1'b1;
        state_next    = S_TMP_W;
      end
      S_TMP_W: begin
        cmd.div_sel  = DV_TEMP;
        cmd.div_wait = 1'b1;
        if (stat.div_done) begin
          state_next = S_SPL_GO;
        end
      end
      S_SPL_GO: begin
        cmd.div_sel   = DV_SPLIT;
        cmd.div_start = 1'b1;
        state_next    = S_SPL_W;
      end
      S_SPL_W: begin
        cmd.div_sel  = DV_SPLIT;
        cmd.div_wait = 1'b1;
        if (stat.div_done) begin
          state_next = S_PTR_GO;
        end
      end
      S_PTR_GO: begin
        cmd.div_sel   = DV_PTR;
        cmd.div_start = 1'b1;
        state_next    = S_PTR_W;
      end
      S_PTR_W: begin
        cmd.div_sel  = DV_PTR;
        cmd.div_wait = 1'b1;
        if (stat.div_done) begin
          if (!stat.sub_zero) begin
            cmd.load   = LD_ZERO;
            state_next = S_ALL_RD;
          end else begin
            cmd.load   = LD_DIVR;
            state_next = stat.left_zero ? S_DONE : S_LFT_RD;
          end
        end
      end
      S_ALL_RD: begin
        state_next = S_ALL_WR;
      end
      S_ALL_WR: begin
        cmd.wr   = WR_DEC;
        cmd.step = 1'b1;
        cmd.wrap = 1'b1;
        if (stat.cnt_last) begin
          cmd.load   = LD_PTR;
          state_next = stat.left_zero ? S_DONE : S_LFT_RD;
        end else begin
          state_next = S_ALL_RD;
        end
      end
      S_LFT_RD: begin
        state_next = S_LFT_WR;
      end
      S_LFT_WR: begin
        cmd.wr      = WR_DEC;
        cmd.dec_one = 1'b1;
        cmd.step    = 1'b1;
        cmd.wrap    = 1'b1;
        cmd.lim     = LIM_LEFT;
        state_next  = stat.cnt_last ? S_DONE : S_LFT_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/swcb_dp.sv */
// ----------------------------------------------------------------------------
// swcb_dp
// Datapath: configuration registers, hash mixer, shared divider, cell
// memory with sweep address counter, zero count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swcb_dp
  import swcb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [DataW-1:0]   cfg_data,
  input  wire logic               op,
  input  wire logic [DataW-1:0]   key,
  input  wire logic               out_stall,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  output logic                    out_valid,
  output logic [AddrW-1:0]        cell_index,
  output logic [CntW-1:0]         zero_cells
);

  // Configuration
  logic [CntW-1:0]  cell_count;
  logic [WinW-1:0]  window_ticks;
  logic [BitsW-1:0] counter_bits;
  logic [DataW-1:0] hash_seed;
  logic             dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count   <= CntW'(4096);
      window_ticks <= WinW'(4096);
      counter_bits <= BitsW'(2);
      hash_seed    <= DataW'(2);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_COUNT: cell_count   <= cfg_data[CntW-1:0];
        REG_WINDOW:     window_ticks <= cfg_data[WinW-1:0];
        REG_BITS:       counter_bits <= cfg_data[BitsW-1:0];
        REG_SEED:       hash_seed    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Mark the zero count stale when the cell count changes
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b1;
    end else if (cfg_valid && (cfg_reg_t'(cfg_index) == REG_CELL_COUNT)) begin
      dirty <= 1'b1;
    end else if (cmd.clean) begin
      dirty <= 1'b0;
    end
  end

  // Clamp configuration into range
  logic [CntW-1:0]  n_used;
  logic [BitsW-1:0] bits_used;
  logic [WinW-1:0]  win_used;
  logic [CntW-1:0]  one_sh;
  logic [CellW-1:0] ones;
  logic [CellW-1:0] less2;

  always_comb begin
    if (cell_count == '0) begin
      n_used = CntW'(1);
    end else if (cell_count > CntW'(CellDepth)) begin
      n_used = CntW'(CellDepth);
    end else begin
      n_used = cell_count;
    end
    if (counter_bits < MinBits) begin
      bits_used = MinBits;
    end else if (counter_bits > MaxBits) begin
      bits_used = MaxBits;
    end else begin
      bits_used = counter_bits;
    end
    win_used = (window_ticks == '0) ? WinW'(1) : window_ticks;
  end

  assign one_sh = CntW'(1) << bits_used;
  assign ones   = CellW'(one_sh - CntW'(1));
  assign less2  = CellW'(one_sh - CntW'(2));

  // Hash mixer, one row per cycle
  logic [DataW-1:0]  ha, hb, hc;
  logic [RoundW-1:0] round;
  logic              op_r;
  logic [4:0]        sh;

  assign sh = shift_of(round);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ha    <= Golden + key;
      hb    <= Golden;
      hc    <= hash_seed + DataW'(4);
      round <= '0;
      op_r  <= op;
    end else if (cmd.hash_round) begin
      case (row_of(round))
        ROW_A:   ha <= (ha - hb - hc) ^ (hc >> sh);
        ROW_B:   hb <= (hb - hc - ha) ^ (ha << sh);
        default: hc <= (hc - ha - hb) ^ (hb >> sh);
      endcase
      round <= round + 1'b1;
    end
  end

  // Scaled counter range times cell count
  logic [DataW:0]   prod_full;
  logic [DataW-1:0] prod;

  assign prod_full = less2 * n_used;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= prod_full[DataW-1:0];
    end
  end

  // Shared divider
  logic [DivW-1:0]  div_a;
  logic [WinW-1:0]  div_b;
  logic             div_done;
  logic [DivW-1:0]  div_q;
  logic [WinW-1:0]  div_r;
  logic [DataW-1:0] temp;
  logic [AddrW-1:0] sweep_ptr;
  logic [AddrW-1:0] pos;
  logic [CellW-1:0] sub_all;
  logic [AddrW-1:0] left;
  logic [AddrW-1:0] ptr_mod;

  always_comb begin
    case (cmd.div_sel)
      DV_MOD: begin
        div_a = hc;
        div_b = WinW'(n_used);
      end
      DV_TEMP: begin
        div_a = prod;
        div_b = win_used;
      end
      DV_SPLIT: begin
        div_a = temp;
        div_b = WinW'(n_used);
      end
      default: begin
        div_a = DivW'(sweep_ptr);
        div_b = WinW'(n_used);
      end
    endcase
  end

  swcb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Capture division results
  always_ff @(posedge clk) begin
    if (cmd.div_wait && div_done) begin
      case (cmd.div_sel)
        DV_MOD:   pos <= div_r[AddrW-1:0];
        DV_TEMP:  temp <= div_q;
        DV_SPLIT: begin
          sub_all <= div_q[CellW-1:0];
          left    <= div_r[AddrW-1:0];
        end
        default:  ptr_mod <= div_r[AddrW-1:0];
      endcase
    end
  end

  // Sweep address and count
  logic [AddrW-1:0] addr;
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  addr_inc;
  logic [CntW-1:0]  limit;

  assign addr_inc = {1'b0, addr} + CntW'(1);

  always_comb begin
    case (cmd.lim)
      LIM_FULL: limit = CntW'(CellDepth);
      LIM_LEFT: limit = CntW'(left);
      default:  limit = n_used;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      cnt  <= '0;
    end else begin
      case (cmd.load)
        LD_ZERO: begin
          addr <= '0;
          cnt  <= '0;
        end
        LD_DIVR: begin
          addr <= div_r[AddrW-1:0];
          cnt  <= '0;
        end
        LD_PTR: begin
          addr <= ptr_mod;
          cnt  <= '0;
        end
        default: begin
          if (cmd.step) begin
            addr <= (cmd.wrap && (addr_inc == n_used)) ? '0 : addr_inc[AddrW-1:0];
            cnt  <= cnt + CntW'(1);
          end
        end
      endcase
    end
  end

  // Cell memory
  logic [CellW-1:0] mem [CellDepth];
  logic [CellW-1:0] rd_data;
  logic [CellW-1:0] wr_data;
  logic [CellW-1:0] dec_amt;
  logic [CellW-1:0] dec_val;

  assign dec_amt = cmd.dec_one ? CellW'(1) : sub_all;
  assign dec_val = (rd_data > dec_amt) ? (rd_data - dec_amt) : '0;

  always_comb begin
    case (cmd.wr)
      WR_SET:  wr_data = ones;
      WR_DEC:  wr_data = dec_val;
      default: wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr != WR_NONE) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

  // Zero cell count
  logic [CntW-1:0] zc;

  always_ff @(posedge clk) begin
    if (cmd.zc_clear) begin
      zc <= '0;
    end else if (cmd.zc_count && (rd_data == '0)) begin
      zc <= zc + CntW'(1);
    end else if ((cmd.wr == WR_SET) && (rd_data == '0)) begin
      zc <= zc - CntW'(1);
    end else if ((cmd.wr == WR_DEC) && (rd_data != '0) && (dec_val == '0)) begin
      zc <= zc + CntW'(1);
    end
  end

  // Advance the sweep pointer when an insert completes
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_ptr <= '0;
    end else if (cmd.out_load && (op_r == OP_INSERT)) begin
      sweep_ptr <= addr;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_index <= (op_r == OP_INSERT) ? pos : '0;
      zero_cells <= zc;
    end
  end

  // Status to the controller
  assign stat.dirty      = dirty;
  assign stat.op_insert  = (op_r == OP_INSERT);
  assign stat.round_last = (round == RoundW'(HashRounds - 1));
  assign stat.div_done   = div_done;
  assign stat.cnt_last   = (cnt == limit - CntW'(1));
  assign stat.sub_zero   = (sub_all == '0);
  assign stat.left_zero  = (left == '0);
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

/* sim/tb_sliding_window_clock_bitmap.sv */
// ----------------------------------------------------------------------------
// tb_sliding_window_clock_bitmap
// Self-checking bench for the sliding window clock bitmap. A scoreboard keeps
// its own copy of the cells, the sweep pointer and the registers, predicts the
// cell index and zero count of every request, and checks each result in
// order. Stimulus runs a directed set, then random requests under several
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

class clock_bitmap_scoreboard;
  typedef struct {
    logic [15:0] idx;
    logic [16:0] zeros;
  } bitmap_result_t;

  logic [15:0]    cells [65536];
  logic [31:0]    sweep;
  logic [16:0]    reg_cells;
  logic [20:0]    reg_window;
  logic [4:0]     reg_bits;
  logic [31:0]    reg_seed;
  bitmap_result_t expected_results [$];
  int             errors;

  function new();
    foreach (cells[i]) cells[i] = '0;
    sweep      = 0;
    reg_cells  = 17'd4096;
    reg_window = 21'd4096;
    reg_bits   = 5'd2;
    reg_seed   = 32'd2;
    errors     = 0;
  endfunction

  function void write_reg(swcb_pkg::cfg_reg_t r, logic [31:0] v);
    case (r)
      swcb_pkg::REG_CELL_COUNT: reg_cells  = v[16:0];
      swcb_pkg::REG_WINDOW:     reg_window = v[20:0];
      swcb_pkg::REG_BITS:       reg_bits   = v[4:0];
      default:                  reg_seed   = v;
    endcase
  endfunction

  // One lookup2 mix of a single key
  function logic [31:0] mix_key(logic [31:0] k);
    logic [31:0] a, b, c;
    a = 32'h9e3779b9 + k;
    b = 32'h9e3779b9;
    c = reg_seed + 32'd4;
    a = a - b - c; a = a ^ (c >> 13);
    b = b - c - a; b = b ^ (a << 8);
    c = c - a - b; c = c ^ (b >> 13);
    a = a - b - c; a = a ^ (c >> 12);
    b = b - c - a; b = b ^ (a << 16);
    c = c - a - b; c = c ^ (b >> 5);
    a = a - b - c; a = a ^ (c >> 3);
    b = b - c - a; b = b ^ (a << 10);
    c = c - a - b; c = c ^ (b >> 15);
    return c;
  endfunction

  function void decay(int i, longint unsigned amount);
    if (cells[i] > amount) cells[i] = cells[i] - 16'(amount);
    else cells[i] = '0;
  endfunction

  // Predict the result of one accepted request
  function void note_request(logic op_bit, logic [31:0] k);
    longint unsigned n, bits, win, temp, sub_all, left, p, j;
    bitmap_result_t r;
    int zeros;
    n = (reg_cells < 1) ? 1 : ((reg_cells > 65536) ? 65536 : reg_cells);
    bits = (reg_bits < 2) ? 2 : ((reg_bits > 16) ? 16 : reg_bits);
    win = (reg_window == 0) ? 1 : reg_window;
    r.idx = '0;
    if (op_bit == swcb_pkg::OP_INSERT) begin
      p = mix_key(k) % n;
      r.idx = p[15:0];
      cells[p] = 16'((64'd1 << bits) - 1);
      // advance the clock: whole decay, then the partial run
      temp = ((64'd1 << bits) - 2) * n / win;
      sub_all = temp / n;
      left = temp % n;
      p = sweep % n;
      if (sub_all != 0)
        for (int i = 0; i < n; i++) decay(i, sub_all);
      for (longint unsigned i = 0; i < left; i++) begin
        j = p + i;
        if (j >= n) j = j - n;
        decay(int'(j), 1);
      end
      p = p + left;
      if (p >= n) p = p - n;
      sweep = 32'(p);
    end
    zeros = 0;
    for (int i = 0; i < n; i++) if (cells[i] == 0) zeros++;
    r.zeros = 17'(zeros);
    expected_results.push_back(r);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endfunction

  function void check_result(logic [15:0] idx, logic [16:0] zeros);
    bitmap_result_t r;
    if (expected_results.size() == 0) begin
      report("unexpected result cell_index", idx, 0);
      return;
    end
    r = expected_results.pop_front();
    if (idx !== r.idx) report("cell_index", idx, r.idx);
    if (zeros !== r.zeros) report("zero_cells", zeros, r.zeros);
  endfunction
endclass

module tb_sliding_window_clock_bitmap
  import swcb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 400000;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               op;
  logic [DataW-1:0]   key;
  logic               out_valid;
  logic               out_stall;
  logic [AddrW-1:0]   cell_index;
  logic [CntW-1:0]    zero_cells;

  clock_bitmap_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  sliding_window_clock_bitmap i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .key,
    .out_valid, .out_stall, .cell_index, .zero_cells
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Randomly stall the result side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check results and watch for a hang
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(cell_index, zero_cells);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_sliding_window_clock_bitmap: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(r, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send one request; valid stays high for a following request
  task automatic send_request(op_t o, logic [31:0] k);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op  = o;
    key = k;
    do @(posedge clk); while (in_stall);
    sb.note_request(o, k);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] n, logic [31:0] win, logic [31:0] bits,
                           logic [31:0] seed, int count, ref int done);
    drain();
    write_reg(REG_CELL_COUNT, n);
    write_reg(REG_WINDOW, win);
    write_reg(REG_BITS, bits);
    write_reg(REG_SEED, seed);
    for (int i = 0; i < count; i++) begin
      // rotate idling over the whole random run
      case (done * 3 / 1450)
        0: begin send_idle_pct = 23; recv_stall_pct = 64; end
        1: begin send_idle_pct = 64; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // hold off until every outstanding result is back
      if (i == count / 2) drain();
      send_request(($urandom_range(3) == 0) ? OP_QUERY : OP_INSERT, $urandom());
      done++;
    end
  endtask

  initial begin
    int done;
    done = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_CELL_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_INSERT;
    key = '0;
    out_stall = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: key extremes, both operations, repeated keys at reset settings
    send_idle_pct = 23;
    recv_stall_pct = 64;
    send_request(OP_QUERY, 32'h0);
    send_request(OP_INSERT, 32'h0);
    send_request(OP_INSERT, 32'hffffffff);
    send_request(OP_INSERT, 32'h0);
    send_request(OP_QUERY, 32'hffffffff);
    send_request(OP_INSERT, 32'haaaaaaaa);
    send_request(OP_INSERT, 32'h55555555);
    send_request(OP_INSERT, 32'h80000000);
    send_request(OP_INSERT, 32'h00000001);
    for (int i = 0; i < 8; i++) send_request(OP_INSERT, 32'h1 << (i * 4));
    send_request(OP_QUERY, 32'h12345678);

    // whole decay every tick, smallest cells
    run_phase(16, 1, 2, 32'hffffffff, 200, done);
    // zero cell count, zero window, zero bits
    run_phase(0, 0, 0, 0, 100, done);
    run_phase(37, 50, 5, 32'hffffffff, 300, done);
    run_phase(200, 1000, 16, $urandom(), 250, done);
    // out-of-range cell count saturates to the full store
    run_phase(32'h1ffff, 32'h1fffff, 2, $urandom(), 10, done);
    // shrink cells so the sweep pointer lies past the end, bits too wide
    run_phase(50, 1048576, 31, $urandom(), 200, done);
    run_phase(1000, 300, 4, $urandom(), 200, done);
    run_phase(16, 8, 1, 32'h0, 190, done);

    drain();
    if (sb.errors == 0) begin
      $display("tb_sliding_window_clock_bitmap: clean");
    end else begin
      $display("tb_sliding_window_clock_bitmap: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
hdl/swcb_pkg.sv
hdl/swcb_div.sv
hdl/swcb_ctrl.sv
hdl/swcb_dp.sv
hdl/sliding_window_clock_bitmap.sv
sim/tb_sliding_window_clock_bitmap.sv
